FILE: sv/olm_pkg.sv
// Shared types and constants for the ordered list manager.
// Operation and status codes, sequencer states and default sizes.
// No dependencies.
package olm_pkg;

    // Default store geometry
    localparam int OLM_CAPACITY   = 16;
    localparam int OLM_DATA_WIDTH = 32;

    // Field widths fixed by the interface
    localparam int KIND_W     = 2;
    localparam int VALUE_W    = 32;
    localparam int POSITION_W = 6;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_DUMP   = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE     = 3'd0,
        STAT_RANGE    = 3'd1,
        STAT_NOTFOUND = 3'd2,
        STAT_FULL     = 3'd3,
        STAT_ELEMENT  = 3'd4,
        STAT_EMPTY    = 3'd5
    } t_status;

    // S_RESP sends the single result of a non-dump operation or of a dump of an empty list
    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC,
        S_TAIL_WALK,
        S_INS_WALK,
        S_INS_LINK,
        S_REM_WALK,
        S_REM_FREE,
        S_DUMP_WALK,
        S_RESP
    } t_state;

endpackage

FILE: sv/ordered_list_manager.sv
// Ordered list manager: singly linked list of values in a fixed node store.
// Link store, value store, free list and the walk sequencer.
// Depends on olm_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one operation per
//   transaction: append, insert before a 1-based position, remove the first
//   matching value, or dump the list. Output channel (o_out_valid /
//   i_out_ready) returns one status transaction per operation, or one per
//   node for a dump, with o_last on the final one and o_count after the op.
//   Timing: the block takes one operation at a time; o_in_ready is high only
//   while the sequencer is idle. One link-store read per cycle sets the pace
//   of every chain walk, and a dump walk also waits on output stalls. An
//   append to a non-empty list walks to the tail, an insert at position P
//   above 1 walks to the node before it, a remove walks to the first match
//   and a dump walks every node. Range, full and empty answers skip the walk.
//   Reset: the list is empty and all nodes sit on the free list; link
//   entries read as their chained reset value until first written.
//   Back-pressure: a finished result waits in the output register; the next
//   operation is still taken while it waits, and a dump walk holds its place
//   until the receiver takes each element.
module ordered_list_manager #(
    parameter int CAPACITY   = olm_pkg::OLM_CAPACITY,
    parameter int DATA_WIDTH = olm_pkg::OLM_DATA_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  olm_pkg::t_kind                    i_kind,
    input  logic signed [olm_pkg::VALUE_W-1:0] i_value,
    input  logic [olm_pkg::POSITION_W-1:0]    i_position,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output olm_pkg::t_status                  o_status,
    output logic signed [olm_pkg::VALUE_W-1:0] o_element,
    output logic                              o_last,
    output logic [olm_pkg::COUNT_W-1:0]       o_count
);
    import olm_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [PW-1:0] NIL      = PW'(CAPACITY);
    localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);
    localparam logic [CW-1:0] LAST_STEP = CW'(CAPACITY - 1);

    // Node stores
    logic [PW-1:0]         link_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] val_mem  [CAPACITY];
    logic [CAPACITY-1:0]   r_lvalid;

    // Sequencer state
    t_state                r_state, n_state;
    logic [PW-1:0]         r_head, n_head;
    logic [PW-1:0]         r_free, n_free;
    logic [CW-1:0]         r_count, n_count;
    logic [PW-1:0]         r_cur, n_cur;
    logic [PW-1:0]         r_prev, n_prev;
    logic [PW-1:0]         r_new, n_new;
    logic [CW-1:0]         r_steps, n_steps;
    logic [POSITION_W-1:0] r_idx, n_idx;
    t_status               r_status, n_status;

    // Latched operation
    t_kind                 r_kind;
    logic [VALUE_W-1:0]    r_value;
    logic [POSITION_W-1:0] r_pos;

    // Registered read data for the node at r_cur
    logic [PW-1:0]         r_rd_link;
    logic [DATA_WIDTH-1:0] r_rd_val;

    // Output register
    logic                  r_out_valid;
    t_status               r_out_status;
    logic [VALUE_W-1:0]    r_out_elem;
    logic                  r_out_last;
    logic [CW-1:0]         r_out_count;

    // Combinational controls
    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_ld_out;
    t_status               w_out_status;
    logic [VALUE_W-1:0]    w_out_elem;
    logic                  w_out_last;
    logic                  w_lwe;
    logic [PW-1:0]         w_lwa;
    logic [PW-1:0]         w_lwd;
    logic                  w_vwe;
    logic [AW-1:0]         w_rd_addr;
    logic                  w_head_ok, w_free_ok, w_prev_ok, w_link_ok;
    logic                  w_pos_bad;
    logic [63:0]           w_val64;
    logic [63:0]           w_rdv64;
    logic [DATA_WIDTH-1:0] w_val_d;
    logic [63:0]           w_cnt64;

    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_head_ok = (r_head < NIL);
    assign w_free_ok = (r_free < NIL);
    assign w_prev_ok = (r_prev < NIL);
    assign w_link_ok = (r_rd_link < NIL);
    assign w_pos_bad = (i_position == '0) || (8'(i_position) > 8'(r_count));

    // Fit the operand to the stored width, and stored data to the port width
    assign w_val64 = 64'(r_value);
    assign w_val_d = w_val64[DATA_WIDTH-1:0];
    assign w_rdv64 = 64'(r_rd_val);

    // Always read the node that r_cur will point at next cycle
    assign w_rd_addr = (n_cur < NIL) ? n_cur[AW-1:0] : '0;

    // Sequencer: next state, list pointers and store writes
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_free       = r_free;
        n_count      = r_count;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_new        = r_new;
        n_steps      = r_steps;
        n_idx        = r_idx;
        n_status     = r_status;
        w_lwe        = 1'b0;
        w_lwa        = r_cur;
        w_lwd        = NIL;
        w_vwe        = 1'b0;
        w_ld_out     = 1'b0;
        w_out_status = STAT_DONE;
        w_out_elem   = '0;
        w_out_last   = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_kind)
                        KIND_APPEND: begin
                            if (!w_free_ok) begin
                                n_status = STAT_FULL;
                                n_state  = S_RESP;
                            end else begin
                                n_new   = r_free;
                                n_cur   = r_free;
                                n_state = S_ALLOC;
                            end
                        end
                        KIND_INSERT: begin
                            if (w_pos_bad) begin
                                n_status = STAT_RANGE;
                                n_state  = S_RESP;
                            end else if (!w_free_ok) begin
                                n_status = STAT_FULL;
                                n_state  = S_RESP;
                            end else begin
                                n_new   = r_free;
                                n_cur   = r_free;
                                n_state = S_ALLOC;
                            end
                        end
                        KIND_REMOVE: begin
                            if (!w_head_ok) begin
                                n_status = STAT_NOTFOUND;
                                n_state  = S_RESP;
                            end else begin
                                n_cur   = r_head;
                                n_prev  = NIL;
                                n_steps = '0;
                                n_state = S_REM_WALK;
                            end
                        end
                        KIND_DUMP: begin
                            if (!w_head_ok) begin
                                n_status = STAT_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_cur   = r_head;
                                n_steps = '0;
                                n_state = S_DUMP_WALK;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            // Pop the free list and store the value; link the new node for an append or a head insert
            S_ALLOC: begin
                n_free = r_rd_link;
                w_vwe  = 1'b1;
                if (r_kind == KIND_APPEND) begin
                    w_lwe = 1'b1;
                    w_lwa = r_new;
                    w_lwd = NIL;
                    if (!w_head_ok) begin
                        n_head   = r_new;
                        n_count  = r_count + CW'(1);
                        n_status = STAT_DONE;
                        n_state  = S_RESP;
                    end else begin
                        n_cur   = r_head;
                        n_steps = '0;
                        n_state = S_TAIL_WALK;
                    end
                end else if (r_pos == POSITION_W'(1)) begin
                    w_lwe    = 1'b1;
                    w_lwa    = r_new;
                    w_lwd    = r_head;
                    n_head   = r_new;
                    n_count  = r_count + CW'(1);
                    n_status = STAT_DONE;
                    n_state  = S_RESP;
                end else begin
                    n_cur   = r_head;
                    n_idx   = POSITION_W'(1);
                    n_state = S_INS_WALK;
                end
            end
            // Advance to the tail, then hook the new node on
            S_TAIL_WALK: begin
                if (!w_link_ok || (r_steps >= LAST_STEP)) begin
                    w_lwe    = 1'b1;
                    w_lwa    = r_cur;
                    w_lwd    = r_new;
                    n_count  = r_count + CW'(1);
                    n_status = STAT_DONE;
                    n_state  = S_RESP;
                end else begin
                    n_cur   = r_rd_link;
                    n_steps = r_steps + CW'(1);
                end
            end
            // Advance to the node before the insert position
            S_INS_WALK: begin
                if (r_idx == (r_pos - POSITION_W'(1))) begin
                    w_lwe   = 1'b1;
                    w_lwa   = r_new;
                    w_lwd   = r_rd_link;
                    n_state = S_INS_LINK;
                end else begin
                    n_cur = r_rd_link;
                    n_idx = r_idx + POSITION_W'(1);
                end
            end
            S_INS_LINK: begin
                w_lwe    = 1'b1;
                w_lwa    = r_cur;
                w_lwd    = r_new;
                n_count  = r_count + CW'(1);
                n_status = STAT_DONE;
                n_state  = S_RESP;
            end
            // Search for the first match and unlink it
            S_REM_WALK: begin
                if (r_rd_val == w_val_d) begin
                    if (w_prev_ok) begin
                        w_lwe = 1'b1;
                        w_lwa = r_prev;
                        w_lwd = r_rd_link;
                    end else begin
                        n_head = r_rd_link;
                    end
                    n_state = S_REM_FREE;
                end else if (!w_link_ok || (r_steps >= LAST_STEP)) begin
                    n_status = STAT_NOTFOUND;
                    n_state  = S_RESP;
                end else begin
                    n_prev  = r_cur;
                    n_cur   = r_rd_link;
                    n_steps = r_steps + CW'(1);
                end
            end
            // Push the removed node onto the free list
            S_REM_FREE: begin
                w_lwe  = 1'b1;
                w_lwa  = r_cur;
                w_lwd  = r_free;
                n_free = r_cur;
                if (r_count != '0) begin
                    n_count = r_count - CW'(1);
                end
                n_status = STAT_DONE;
                n_state  = S_RESP;
            end
            // Emit one element per node; hold while the receiver stalls
            S_DUMP_WALK: begin
                if (w_out_free) begin
                    w_ld_out     = 1'b1;
                    w_out_status = STAT_ELEMENT;
                    w_out_elem   = w_rdv64[VALUE_W-1:0];
                    w_out_last   = !w_link_ok || (r_steps >= LAST_STEP);
                    if (w_out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cur   = r_rd_link;
                        n_steps = r_steps + CW'(1);
                    end
                end
            end
            S_RESP: begin
                if (w_out_free) begin
                    w_ld_out     = 1'b1;
                    w_out_status = r_status;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= NIL;
            r_free  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_free  <= n_free;
            r_count <= n_count;
        end
    end

    // Walk registers and latched operation
    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_new    <= n_new;
        r_steps  <= n_steps;
        r_idx    <= n_idx;
        r_status <= n_status;
        if (w_accept) begin
            r_kind  <= i_kind;
            r_value <= i_value;
            r_pos   <= i_position;
        end
    end

    // Link entries read as their chained reset value until first written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvalid <= '0;
        end else if (w_lwe) begin
            r_lvalid[w_lwa[AW-1:0]] <= 1'b1;
        end
    end

    // Link store: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (w_lwe) begin
            link_mem[w_lwa[AW-1:0]] <= w_lwd;
        end
        r_rd_link <= r_lvalid[w_rd_addr] ? link_mem[w_rd_addr]
                                         : (PW'(w_rd_addr) + PW'(1));
    end

    // Value store: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (w_vwe) begin
            val_mem[r_new[AW-1:0]] <= w_val_d;
        end
        r_rd_val <= val_mem[w_rd_addr];
    end

    // Output register: load a result or drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ld_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_out) begin
            r_out_status <= w_out_status;
            r_out_elem   <= w_out_elem;
            r_out_last   <= w_out_last;
            r_out_count  <= r_count;
        end
    end

    assign w_cnt64     = 64'(r_out_count);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_element   = r_out_elem;
    assign o_last      = r_out_last;
    assign o_count     = w_cnt64[COUNT_W-1:0];

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("entry count exceeds capacity");

    a_free_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_free == NIL) == (r_count == CAP_CNT)))
        else $error("free list disagrees with entry count");

    a_head_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_head == NIL) == (r_count == '0)))
        else $error("list head disagrees with entry count");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ld_out |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over a pending transaction");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("sequencer stayed idle after accepting a transaction");
`endif

endmodule
